@@ sv/dst_pkg.sv @@
// ----------------------------------------------------------------------------
// dst_pkg
// Types and codes shared by the device slot table and its match unit.
// ----------------------------------------------------------------------------
package dst_pkg;

   typedef enum logic [2:0] {
      OP_ADD_FREE = 3'd0,
      OP_ADD_AT   = 3'd1,
      OP_REMOVE   = 3'd2,
      OP_FIND     = 3'd3,
      OP_READ     = 3'd4
   } opcode_type;

   typedef struct packed {
      logic [7:0] device_address;
      logic [7:0] interface_index;
   } key_type;

   typedef struct packed {
      key_type     key;
      logic [7:0]  protocol;
      logic [15:0] vendor_id;
      logic [15:0] product_id;
      logic        keyboard;
      logic        report_id;
      logic [15:0] desc_length;
   } entry_type;

endpackage

@@ sv/dst_match.sv @@
// ----------------------------------------------------------------------------
// dst_match
// Associative key match over all slots and first-free search, both with
// lowest-index priority.
// ----------------------------------------------------------------------------
module dst_match #(
   parameter int SLOT_COUNT = 8,
   parameter int SW         = 3
) (
   input  dst_pkg::key_type      key,
   input  logic [SLOT_COUNT-1:0] slot_valid,
   input  dst_pkg::key_type      slot_key [SLOT_COUNT],
   output logic                  hit,
   output logic [SW-1:0]         hit_idx,
   output logic                  free,
   output logic [SW-1:0]         free_idx
);
   import dst_pkg::*;

   logic [SLOT_COUNT-1:0] match;

   always_comb begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
         match[s] = slot_valid[s] && (slot_key[s] == key);
      end
   end

   // walk from the top so the lowest index wins
   always_comb begin
      hit      = 1'b0;
      hit_idx  = '0;
      free     = 1'b0;
      free_idx = '0;
      for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
         if (match[s]) begin
            hit     = 1'b1;
            hit_idx = SW'(s);
         end
         if (!slot_valid[s]) begin
            free     = 1'b1;
            free_idx = SW'(s);
         end
      end
   end

endmodule

@@ sv/device_slot_table.sv @@
// ----------------------------------------------------------------------------
// device_slot_table
// Small associative table of device slots keyed by device address and
// interface index, with add, remove, find and read commands.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at each rising edge where start is high and busy is low.
//   busy stays low, so an item may be issued in every cycle.
//   Each item gives exactly one result, shown on the rsp_ ports for one cycle
//   with rsp_valid high; the receiver cannot stall, so it must take it then.
//   Throughput is one item per cycle. The item is captured in an input
//   register, then the key match, priority encode and table update run
//   combinationally and land in the result register and the slot registers
//   at the same edge, so back-to-back items see each other's updates.
//   A miss or failure returns success low with all other fields zero.
//   Reset clears every valid bit at once; the table is usable in the first
//   cycle after reset. Entry contents are only visible through valid slots.
// ----------------------------------------------------------------------------
module device_slot_table #(
   parameter int SLOT_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_device_address,
   input  logic [7:0]  req_interface_index,
   input  logic [2:0]  req_slot_index,
   input  logic [7:0]  req_protocol_code,
   input  logic [15:0] req_vendor_id,
   input  logic [15:0] req_product_id,
   input  logic        req_keyboard_flag,
   input  logic        req_report_id_flag,
   input  logic [15:0] req_descriptor_length,
   output logic        rsp_valid,
   output logic        rsp_success,
   output logic [2:0]  rsp_slot_result,
   output logic [7:0]  rsp_out_device_address,
   output logic [7:0]  rsp_out_interface_index,
   output logic [7:0]  rsp_out_protocol,
   output logic [15:0] rsp_out_vendor_id,
   output logic [15:0] rsp_out_product_id,
   output logic        rsp_out_keyboard,
   output logic        rsp_out_report_id,
   output logic [15:0] rsp_out_desc_length
);
   import dst_pkg::*;

   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // input register
   logic                  in_valid_ff;
   logic [2:0]            in_op_ff;
   logic [2:0]            in_slot_ff;
   entry_type             in_entry_ff;

   // table
   logic [SLOT_COUNT-1:0] slot_valid_ff;
   entry_type             slot_entry_ff [SLOT_COUNT];
   key_type               slot_key [SLOT_COUNT];

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_success_ff;
   logic [2:0]            rsp_slot_ff;
   entry_type             rsp_entry_ff;
   logic                  rsp_success_in;
   logic [2:0]            rsp_slot_in;
   entry_type             rsp_entry_in;

   logic                  hit;
   logic [SW-1:0]         hit_idx;
   logic                  free;
   logic [SW-1:0]         free_idx;

   logic                  in_range;
   logic [SW-1:0]         idx_sel;
   logic                  ok;
   logic [SW-1:0]         sel;
   logic                  wr;
   logic                  clr;
   logic                  from_input;
   entry_type             rpt;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start;
      end
      if (start) begin
         in_op_ff                        <= req_opcode;
         in_slot_ff                      <= req_slot_index;
         in_entry_ff.key.device_address  <= req_device_address;
         in_entry_ff.key.interface_index <= req_interface_index;
         in_entry_ff.protocol            <= req_protocol_code;
         in_entry_ff.vendor_id           <= req_vendor_id;
         in_entry_ff.product_id          <= req_product_id;
         in_entry_ff.keyboard            <= req_keyboard_flag;
         in_entry_ff.report_id           <= req_report_id_flag;
         in_entry_ff.desc_length         <= req_descriptor_length;
      end
   end

   always_comb begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
         slot_key[s] = slot_entry_ff[s].key;
      end
   end

   dst_match #(
      .SLOT_COUNT (SLOT_COUNT),
      .SW         (SW)
   ) u_match (
      .key        (in_entry_ff.key),
      .slot_valid (slot_valid_ff),
      .slot_key   (slot_key),
      .hit        (hit),
      .hit_idx    (hit_idx),
      .free       (free),
      .free_idx   (free_idx)
   );

   assign in_range = int'(in_slot_ff) < SLOT_COUNT;
   assign idx_sel  = SW'(in_slot_ff);

   always_comb begin
      ok         = 1'b0;
      sel        = '0;
      wr         = 1'b0;
      clr        = 1'b0;
      from_input = 1'b0;
      case (in_op_ff)
         OP_ADD_FREE: begin
            ok         = free;
            sel        = free_idx;
            wr         = free;
            from_input = 1'b1;
         end
         OP_ADD_AT: begin
            ok         = in_range;
            sel        = idx_sel;
            wr         = in_range;
            from_input = 1'b1;
         end
         OP_REMOVE: begin
            ok  = hit;
            sel = hit_idx;
            clr = hit;
         end
         OP_FIND: begin
            ok  = hit;
            sel = hit_idx;
         end
         OP_READ: begin
            ok  = in_range && slot_valid_ff[idx_sel];
            sel = idx_sel;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // an add reports what it writes; everything else reports the stored slot
   assign rpt            = from_input ? in_entry_ff : slot_entry_ff[sel];
   assign rsp_success_in = ok;
   assign rsp_slot_in    = ok ? 3'(sel) : 3'd0;
   assign rsp_entry_in   = ok ? rpt : '0;

   // removed slots only drop their valid bit: contents are never read
   // again until an add rewrites them
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (in_valid_ff) begin
         if (wr) begin
            slot_valid_ff[sel] <= 1'b1;
         end
         if (clr) begin
            slot_valid_ff[sel] <= 1'b0;
         end
      end
      if (in_valid_ff && wr) begin
         slot_entry_ff[sel] <= in_entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid_ff;
      end
      rsp_success_ff <= rsp_success_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_entry_ff   <= rsp_entry_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_success             = rsp_success_ff;
   assign rsp_slot_result         = rsp_slot_ff;
   assign rsp_out_device_address  = rsp_entry_ff.key.device_address;
   assign rsp_out_interface_index = rsp_entry_ff.key.interface_index;
   assign rsp_out_protocol        = rsp_entry_ff.protocol;
   assign rsp_out_vendor_id       = rsp_entry_ff.vendor_id;
   assign rsp_out_product_id      = rsp_entry_ff.product_id;
   assign rsp_out_keyboard        = rsp_entry_ff.keyboard;
   assign rsp_out_report_id       = rsp_entry_ff.report_id;
   assign rsp_out_desc_length     = rsp_entry_ff.desc_length;

endmodule

@@ sim/device_slot_table_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// device_slot_table_checker
// Watches the command and response ports of the device slot table, keeps a
// private copy of the slot contents, predicts the answer to every accepted
// item and compares each response against the oldest prediction.
// ----------------------------------------------------------------------------
module device_slot_table_checker #(
   parameter int SLOT_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_device_address,
   input  logic [7:0]  req_interface_index,
   input  logic [2:0]  req_slot_index,
   input  logic [7:0]  req_protocol_code,
   input  logic [15:0] req_vendor_id,
   input  logic [15:0] req_product_id,
   input  logic        req_keyboard_flag,
   input  logic        req_report_id_flag,
   input  logic [15:0] req_descriptor_length,
   input  logic        rsp_valid,
   input  logic        rsp_success,
   input  logic [2:0]  rsp_slot_result,
   input  logic [7:0]  rsp_out_device_address,
   input  logic [7:0]  rsp_out_interface_index,
   input  logic [7:0]  rsp_out_protocol,
   input  logic [15:0] rsp_out_vendor_id,
   input  logic [15:0] rsp_out_product_id,
   input  logic        rsp_out_keyboard,
   input  logic        rsp_out_report_id,
   input  logic [15:0] rsp_out_desc_length,
   output int          fail_count,
   output int          outstanding
);
   import dst_pkg::*;

   typedef struct packed {
      logic       success;
      logic [2:0] slot;
      entry_type  entry;
   } answer_type;

   logic       slot_live [SLOT_COUNT];
   entry_type  slot_entry [SLOT_COUNT];
   answer_type pending_answers [$];
   int         mismatches = 0;

   function automatic answer_type slot_answer(int s);
      answer_type ans;
      ans.success = 1'b1;
      ans.slot    = s[2:0];
      ans.entry   = slot_entry[s];
      return ans;
   endfunction

   // lowest live slot holding the key, -1 on a miss
   function automatic int key_lookup(key_type key);
      int s;
      for (s = 0; s < SLOT_COUNT; s++) begin
         if (slot_live[s] && slot_entry[s].key == key) begin
            return s;
         end
      end
      return -1;
   endfunction

   // updates the table copy and returns the answer the block should give
   function automatic answer_type apply_command(logic [2:0] op, logic [2:0] idx,
                                                entry_type item);
      answer_type ans;
      int         s;
      int         hit;
      ans = '0;
      hit = -1;
      case (op)
         OP_ADD_FREE: begin
            for (s = SLOT_COUNT - 1; s >= 0; s--) begin
               if (!slot_live[s]) begin
                  hit = s;
               end
            end
            if (hit >= 0) begin
               slot_live[hit]  = 1'b1;
               slot_entry[hit] = item;
               ans = slot_answer(hit);
            end
         end
         OP_ADD_AT: begin
            if (idx < SLOT_COUNT) begin
               slot_live[idx]  = 1'b1;
               slot_entry[idx] = item;
               ans = slot_answer(idx);
            end
         end
         OP_REMOVE: begin
            hit = key_lookup(item.key);
            if (hit >= 0) begin
               ans = slot_answer(hit);
               slot_live[hit]  = 1'b0;
               slot_entry[hit] = '0;
            end
         end
         OP_FIND: begin
            hit = key_lookup(item.key);
            if (hit >= 0) begin
               ans = slot_answer(hit);
            end
         end
         OP_READ: begin
            if (idx < SLOT_COUNT && slot_live[idx]) begin
               ans = slot_answer(idx);
            end
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   function automatic int field_differs(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : monitor
      answer_type want;
      answer_type got;
      entry_type  item;
      if (reset) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_live[s]  = 1'b0;
            slot_entry[s] = '0;
         end
         pending_answers.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_answers.size() == 0) begin
               $error("response with no item pending");
               mismatches++;
            end else begin
               want = pending_answers.pop_front();
               got.success                    = rsp_success;
               got.slot                       = rsp_slot_result;
               got.entry.key.device_address   = rsp_out_device_address;
               got.entry.key.interface_index  = rsp_out_interface_index;
               got.entry.protocol             = rsp_out_protocol;
               got.entry.vendor_id            = rsp_out_vendor_id;
               got.entry.product_id           = rsp_out_product_id;
               got.entry.keyboard             = rsp_out_keyboard;
               got.entry.report_id            = rsp_out_report_id;
               got.entry.desc_length          = rsp_out_desc_length;
               mismatches += field_differs("success",
                  16'(want.success), 16'(got.success));
               mismatches += field_differs("slot_result",
                  16'(want.slot), 16'(got.slot));
               mismatches += field_differs("out_device_address",
                  16'(want.entry.key.device_address), 16'(got.entry.key.device_address));
               mismatches += field_differs("out_interface_index",
                  16'(want.entry.key.interface_index), 16'(got.entry.key.interface_index));
               mismatches += field_differs("out_protocol",
                  16'(want.entry.protocol), 16'(got.entry.protocol));
               mismatches += field_differs("out_vendor_id",
                  want.entry.vendor_id, got.entry.vendor_id);
               mismatches += field_differs("out_product_id",
                  want.entry.product_id, got.entry.product_id);
               mismatches += field_differs("out_keyboard",
                  16'(want.entry.keyboard), 16'(got.entry.keyboard));
               mismatches += field_differs("out_report_id",
                  16'(want.entry.report_id), 16'(got.entry.report_id));
               mismatches += field_differs("out_desc_length",
                  want.entry.desc_length, got.entry.desc_length);
            end
         end
         if (start && !busy) begin
            item.key.device_address  = req_device_address;
            item.key.interface_index = req_interface_index;
            item.protocol            = req_protocol_code;
            item.vendor_id           = req_vendor_id;
            item.product_id          = req_product_id;
            item.keyboard            = req_keyboard_flag;
            item.report_id           = req_report_id_flag;
            item.desc_length         = req_descriptor_length;
            pending_answers.push_back(apply_command(req_opcode, req_slot_index, item));
         end
      end
      fail_count  <= mismatches;
      outstanding <= pending_answers.size();
   end

endmodule

@@ sim/device_slot_table_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// device_slot_table_test
// Drives the device slot table with a directed sequence (empty table, full
// table, overwrite, duplicate keys, remove, unused opcodes) and then with
// random add/remove/find/read traffic over a small pool of keys, alternating
// fill-heavy and drain-heavy phases. The checker predicts and compares.
// ----------------------------------------------------------------------------
module device_slot_table_test;
   import dst_pkg::*;

   localparam int         SLOT_COUNT   = 8;
   localparam int         RANDOM_ITEMS = 800;
   localparam int         CYCLE_LIMIT  = 50000;
   localparam int         KEY_POOL     = 6;
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_opcode = '0;
   logic [7:0]  req_device_address = '0;
   logic [7:0]  req_interface_index = '0;
   logic [2:0]  req_slot_index = '0;
   logic [7:0]  req_protocol_code = '0;
   logic [15:0] req_vendor_id = '0;
   logic [15:0] req_product_id = '0;
   logic        req_keyboard_flag = 1'b0;
   logic        req_report_id_flag = 1'b0;
   logic [15:0] req_descriptor_length = '0;
   logic        rsp_valid;
   logic        rsp_success;
   logic [2:0]  rsp_slot_result;
   logic [7:0]  rsp_out_device_address;
   logic [7:0]  rsp_out_interface_index;
   logic [7:0]  rsp_out_protocol;
   logic [15:0] rsp_out_vendor_id;
   logic [15:0] rsp_out_product_id;
   logic        rsp_out_keyboard;
   logic        rsp_out_report_id;
   logic [15:0] rsp_out_desc_length;

   int          fail_count;
   int          outstanding;
   int          cycle_count = 0;
   bit          allow_gaps = 1'b1;
   key_type     key_pool [KEY_POOL];

   always #1 clock = ~clock;

   device_slot_table #(.SLOT_COUNT(SLOT_COUNT)) u_dut (.*);

   device_slot_table_checker #(.SLOT_COUNT(SLOT_COUNT)) u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic key_type pick_key();
      key_type key;
      if ($urandom_range(99) < 75) begin
         key = key_pool[$urandom_range(KEY_POOL - 1)];
      end else begin
         key = key_type'($urandom);
      end
      return key;
   endfunction

   function automatic entry_type random_entry();
      entry_type e;
      e.key         = pick_key();
      e.protocol    = 8'($urandom);
      e.vendor_id   = 16'($urandom);
      e.product_id  = 16'($urandom);
      e.keyboard    = 1'($urandom);
      e.report_id   = 1'($urandom);
      e.desc_length = 16'($urandom);
      return e;
   endfunction

   // call right after a rising edge; returns at the edge that takes the item
   task automatic send(logic [2:0] op, logic [2:0] idx, entry_type e);
      while (allow_gaps && $urandom_range(99) < 37) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_opcode            <= op;
      req_slot_index        <= idx;
      req_device_address    <= e.key.device_address;
      req_interface_index   <= e.key.interface_index;
      req_protocol_code     <= e.protocol;
      req_vendor_id         <= e.vendor_id;
      req_product_id        <= e.product_id;
      req_keyboard_flag     <= e.keyboard;
      req_report_id_flag    <= e.report_id;
      req_descriptor_length <= e.desc_length;
      start                 <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [2:0] pick_opcode(bit filling);
      int r;
      r = $urandom_range(99);
      if (r < 5) begin
         return 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end
      if (filling) begin
         if (r < 45) return OP_ADD_FREE;
         if (r < 55) return OP_ADD_AT;
         if (r < 70) return OP_REMOVE;
         if (r < 85) return OP_FIND;
         return OP_READ;
      end
      if (r < 15) return OP_ADD_FREE;
      if (r < 20) return OP_ADD_AT;
      if (r < 60) return OP_REMOVE;
      if (r < 80) return OP_FIND;
      return OP_READ;
   endfunction

   initial begin
      entry_type zero_entry;
      entry_type ones_entry;
      entry_type e;
      zero_entry = '0;
      ones_entry = '1;
      foreach (key_pool[k]) begin
         key_pool[k] = key_type'($urandom);
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty table: every lookup misses
      send(OP_READ, 3'd0, zero_entry);
      send(OP_FIND, 3'd0, zero_entry);
      send(OP_REMOVE, 3'd0, zero_entry);
      // fill all slots; slot 5 repeats the key of slot 0
      send(OP_ADD_FREE, 3'd0, zero_entry);
      send(OP_ADD_FREE, 3'd0, ones_entry);
      for (int s = 2; s < SLOT_COUNT; s++) begin
         e = random_entry();
         if (s == 5) begin
            e.key = zero_entry.key;
         end
         send(OP_ADD_FREE, 3'($urandom), e);
      end
      // table full
      send(OP_ADD_FREE, 3'd0, random_entry());
      send(OP_ADD_AT, 3'd7, ones_entry);
      // duplicate key: lowest slot wins, then the next one
      send(OP_FIND, 3'd0, zero_entry);
      send(OP_REMOVE, 3'd0, zero_entry);
      send(OP_FIND, 3'd0, zero_entry);
      send(OP_READ, 3'd0, zero_entry);
      send(OP_READ, 3'd7, zero_entry);
      send(OP_ADD_FREE, 3'd0, random_entry());
      for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++) begin
         send(3'(op), 3'($urandom), random_entry());
      end
      send(OP_REMOVE, 3'd0, ones_entry);
      send(OP_READ, 3'd1, zero_entry);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         allow_gaps = !(n >= 300 && n < 450);
         if (n == 200 || n == 600) begin
            drain();
         end
         send(pick_opcode((n / 64) % 2 == 0), 3'($urandom), random_entry());
      end

      drain();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/dst_pkg.sv
sv/dst_match.sv
sv/device_slot_table.sv
sim/device_slot_table_checker.sv
sim/device_slot_table_test.sv
